// ===== rtl/core/ofd_pkg.sv =====
package ofd_pkg;

    // Default geometry of the dilation window and the line stores.
    localparam int RADIUS_DEF    = 2;
    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration port layout.
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int MAP_WIDTH_W  = 11;
    localparam int MAP_HEIGHT_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 1'b1;

    // Cell command; once all cells are in, any command flushes.
    localparam logic CMD_CELL = 1'b0;

    typedef logic signed [7:0] cell_t;

    localparam cell_t CELL_UNKNOWN = cell_t'(-1);
    localparam cell_t CELL_FREE    = cell_t'(0);

endpackage

// ===== rtl/core/ofd_in_if.sv =====
interface ofd_in_if
    import ofd_pkg::*;
();

    logic  valid;
    logic  ready;
    logic  cmd;
    cell_t cell_value;

    modport source (output valid, output cmd, output cell_value, input ready);
    modport sink   (input valid, input cmd, input cell_value, output ready);

endinterface

// ===== rtl/core/ofd_out_if.sv =====
interface ofd_out_if
    import ofd_pkg::*;
();

    logic  valid;
    logic  ready;
    cell_t out_value;
    logic  end_of_map;

    modport source (output valid, output out_value, output end_of_map, input ready);
    modport sink   (input valid, input out_value, input end_of_map, output ready);

endinterface

// ===== rtl/core/ofd_ram.sv =====
module ofd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/occupancy_free_dilation_top.sv =====
// Latency: the result for a cell is formed when the cell RADIUS rows plus RADIUS cells later is
// accepted (or by a flush tick at the end of the map); it goes through s1_reg to the output
// register. Throughput: one transaction per cycle while the skid stage is empty; at the end
// of a map under RADIUS rows plus RADIUS cells the input stalls while the line stores prefetch.
// Reset (rst_n, asynchronous, active low) clears all positions and counters; the line stores
// are not cleared, since cells not written in the current map are masked by row_ok and col_ok.
module occupancy_free_dilation_top
    import ofd_pkg::*;
#(
    parameter int RADIUS    = RADIUS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ofd_in_if.sink                 cells,
    ofd_out_if.source              results
);

    // K rows and K columns make up the square around a center cell.
    localparam int K  = 2 * RADIUS + 1;
    localparam int BW = $clog2(K);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = MAP_HEIGHT_W;
    localparam int PW = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
    localparam int LW = $clog2(RADIUS + 1);

    // Control and payload that travel from the accept stage to the window stage.
    typedef struct packed {
        logic          rd;      // a column was read from the line stores
        logic          emit;    // the shifted window yields a result
        logic          byp;     // the newest row comes from the accepted cell
        logic          last;    // the result is the map's last cell
        logic [BW-1:0] bank;    // store that holds the center row of the read column
        logic [K-1:0]  col_ok;  // window columns that lie in the center's row
        logic [K-1:0]  row_ok;  // window rows that lie inside the map
        cell_t         wval;    // value written in the same cycle
    } s1_t;

    function automatic logic [WW-1:0] eff_width(input logic [MAP_WIDTH_W-1:0] raw);
        logic [WW-1:0] w;
        if (raw == '0)
        begin
            w = WW'(1);
        end
        else if (int'(raw) > MAX_WIDTH)
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(raw);
        end
        return w;
    endfunction

    function automatic logic [RW-1:0] eff_height(input logic [MAP_HEIGHT_W-1:0] raw);
        return (raw == '0) ? RW'(1) : RW'(raw);
    endfunction

    function automatic logic [PW-1:0] lag_of(input logic [WW-1:0] w);
        return PW'(RADIUS * int'(w) + RADIUS);
    endfunction

    // Configuration, kept in its effective form (zero width or height acts as one,
    // an oversized width is clipped to the store size).
    logic [WW-1:0] w_reg;
    logic [RW-1:0] h_reg;
    logic [PW-1:0] lag_reg;

    // Write position, read position (one column of all K rows at a time), result position.
    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [BW-1:0] in_bank_reg;
    logic [CW-1:0] rd_col_reg;
    logic [BW-1:0] rd_bank_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic [PW-1:0] pending_reg;
    logic [LW-1:0] lead_reg;

    logic done;
    logic prefetch;
    logic en;
    logic accept;
    logic cell_evt;
    logic drain_evt;
    logic rd;
    logic emit;
    logic last;
    logic [K-1:0] row_ok;
    logic [K-1:0] col_ok;

    s1_t s1_reg;
    s1_t s1_next;

    logic [$bits(cell_t)-1:0] ram_rdata [K];
    cell_t col_new [K];
    cell_t win_reg [K][K];
    cell_t win_shift [K][K];
    cell_t res_value;
    logic  hit;
    logic  push;
    logic  pop;

    logic  out_valid_reg;
    cell_t out_value_reg;
    logic  out_end_reg;
    logic  skid_valid_reg;
    cell_t skid_value_reg;
    logic  skid_end_reg;

    // ------------------------------------------------------------------------
    // Accept stage.
    // Every cell is written into the store of its row (row modulo K) and, once
    // RADIUS rows are in, each transaction also reads one column of all K stores,
    // RADIUS rows above the cell just written. The window thus runs RADIUS cells
    // ahead of the next result, and a result falls due when the pending count
    // reaches RADIUS rows plus RADIUS cells. After the last cell, flush ticks emit
    // the remaining results; for very small maps the read side first catches up
    // (prefetch) while the input is held off.
    // ------------------------------------------------------------------------
    always_comb
    begin
        done      = in_row_reg >= h_reg;
        prefetch  = done && (pending_reg != '0) && (lead_reg < LW'(RADIUS));
        en        = !skid_valid_reg;
        cells.ready = en && !prefetch;
        accept    = cells.valid && cells.ready;
        cell_evt  = accept && (cells.cmd == CMD_CELL) && !done;
        drain_evt = accept && done && (pending_reg != '0);
        rd        = (cell_evt && (int'(in_row_reg) >= RADIUS)) || drain_evt || (en && prefetch);
        emit      = (cell_evt && (pending_reg >= lag_reg)) || drain_evt;
        last      = emit && (out_row_reg == h_reg - 1'b1)
                    && (WW'(out_col_reg) + WW'(1) == w_reg);
    end

    // Which neighbours of the next result lie inside the map. A window column in
    // another raster row than the center is a neighbour off the left or right edge.
    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            row_ok[i] = (int'(out_row_reg) + i - RADIUS >= 0)
                        && (int'(out_row_reg) + i - RADIUS < int'(h_reg));
            col_ok[i] = (int'(out_col_reg) + i - RADIUS >= 0)
                        && (int'(out_col_reg) + i - RADIUS < int'(w_reg));
        end
    end

    always_comb
    begin
        s1_next.rd     = rd;
        s1_next.emit   = emit;
        s1_next.byp    = cell_evt && rd;
        s1_next.last   = last;
        s1_next.bank   = rd_bank_reg;
        s1_next.col_ok = col_ok;
        s1_next.row_ok = row_ok;
        s1_next.wval   = cells.cell_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= eff_width(MAP_WIDTH_W'(1024));
            h_reg   <= eff_height(MAP_HEIGHT_W'(1024));
            lag_reg <= lag_of(eff_width(MAP_WIDTH_W'(1024)));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:
                begin
                    w_reg   <= eff_width(cfg_data[MAP_WIDTH_W-1:0]);
                    lag_reg <= lag_of(eff_width(cfg_data[MAP_WIDTH_W-1:0]));
                end
                REG_MAP_HEIGHT:
                begin
                    h_reg <= eff_height(cfg_data[MAP_HEIGHT_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Position counters. A configuration write or the map's last result starts a new map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_bank_reg <= '0;
            rd_col_reg  <= '0;
            rd_bank_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            lead_reg    <= '0;
        end
        else if (cfg_we || last)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_bank_reg <= '0;
            rd_col_reg  <= '0;
            rd_bank_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            lead_reg    <= '0;
        end
        else
        begin
            if (cell_evt)
            begin
                if (WW'(in_col_reg) + WW'(1) == w_reg)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + 1'b1;
                    in_bank_reg <= (in_bank_reg == BW'(K - 1)) ? '0 : in_bank_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (rd)
            begin
                if (WW'(rd_col_reg) + WW'(1) == w_reg)
                begin
                    rd_col_reg  <= '0;
                    rd_bank_reg <= (rd_bank_reg == BW'(K - 1)) ? '0 : rd_bank_reg + 1'b1;
                end
                else
                begin
                    rd_col_reg <= rd_col_reg + 1'b1;
                end
            end
            if (emit)
            begin
                if (WW'(out_col_reg) + WW'(1) == w_reg)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
            if (cell_evt && !emit)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (!cell_evt && emit)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (rd && !emit)
            begin
                lead_reg <= lead_reg + 1'b1;
            end
            else if (!rd && emit)
            begin
                lead_reg <= lead_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    // One line store per row modulo K. The read data register holds while the
    // pipeline is stalled, since reads are issued only on advancing cycles.
    for (genvar b = 0; b < K; b++)
    begin : g_bank
        ofd_ram #(
            .WIDTH ($bits(cell_t)),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (cell_evt && (in_bank_reg == BW'(b))),
            .waddr (in_col_reg),
            .wdata (cells.cell_value),
            .re    (rd),
            .raddr (rd_col_reg),
            .rdata (ram_rdata[b])
        );
    end

    // ------------------------------------------------------------------------
    // Window stage.
    // The column read is rotated so that element i holds row offset i - RADIUS.
    // The bottom row was written in the same cycle it was read, so it is taken
    // from the accepted cell rather than from the store.
    // ------------------------------------------------------------------------
    always_comb
    begin
        int unsigned t;
        for (int i = 0; i < K; i++)
        begin
            t = int'(s1_reg.bank) + i + K - RADIUS;
            if (t >= K)
            begin
                t = t - K;
            end
            if (t >= K)
            begin
                t = t - K;
            end
            col_new[i] = cell_t'(ram_rdata[BW'(t)]);
        end
        if (s1_reg.byp)
        begin
            col_new[K-1] = s1_reg.wval;
        end
    end

    always_comb
    begin
        for (int j = 0; j < K - 1; j++)
        begin
            win_shift[j] = win_reg[j + 1];
        end
        win_shift[K-1] = col_new;
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_reg.rd)
        begin
            win_reg <= win_shift;
        end
    end

    // An unknown center turns free when any free cell inside the disk is in the map.
    always_comb
    begin
        hit = 1'b0;
        for (int j = 0; j < K; j++)
        begin
            for (int i = 0; i < K; i++)
            begin
                if ((j - RADIUS) * (j - RADIUS) + (i - RADIUS) * (i - RADIUS)
                    <= RADIUS * RADIUS)
                begin
                    if ((win_shift[j][i] == CELL_FREE) && s1_reg.col_ok[j] && s1_reg.row_ok[i])
                    begin
                        hit = 1'b1;
                    end
                end
            end
        end
        res_value = ((win_shift[RADIUS][RADIUS] == CELL_UNKNOWN) && hit)
                    ? CELL_FREE : win_shift[RADIUS][RADIUS];
    end

    // ------------------------------------------------------------------------
    // Output register with a one-entry skid stage. The pipeline advances while
    // the skid stage is empty, so a new transaction is taken even while a
    // result waits at the output.
    // ------------------------------------------------------------------------
    assign push = en && s1_reg.rd && s1_reg.emit;
    assign pop  = out_valid_reg && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_value_reg <= skid_value_reg;
            out_end_reg   <= skid_end_reg;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            out_value_reg <= res_value;
            out_end_reg   <= s1_reg.last;
        end
        if (push && out_valid_reg && !pop)
        begin
            skid_value_reg <= res_value;
            skid_end_reg   <= s1_reg.last;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_value  = out_value_reg;
    assign results.end_of_map = out_end_reg;

endmodule
